// ===== rtl/core/rsv_pkg.sv =====
// Shared types and constants for the running sample variance block.
package rsv_pkg;

  localparam int SUM_W   = 48;
  localparam int SQ_W    = 64;
  localparam int PSQ_W   = 62;
  localparam int PCNT_W  = 32;
  localparam int VAR_W   = 48;
  localparam int OCNT_W  = 32;
  localparam int OPND_W  = 32;
  localparam int DEN_W   = 64;
  localparam int PROD_W  = 96;
  localparam int MAC_W   = 98;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_MERGE = 2'd1,
    CMD_EMIT  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MAC_LOAD = 2'd0,
    MAC_ADD  = 2'd1,
    MAC_SUB  = 2'd2
  } mac_op_t;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_32 = 2'd1,
    SH_64 = 2'd2
  } mac_sh_t;

  typedef enum logic [2:0] {
    MS_N_LO = 3'd0,
    MS_N_HI = 3'd1,
    MS_A00  = 3'd2,
    MS_A01  = 3'd3,
    MS_A10  = 3'd4,
    MS_A11  = 3'd5
  } mul_step_t;

  typedef struct packed {
    logic              en;
    mac_op_t           op;
    mac_sh_t           sh;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/rsv_if.sv =====
// Valid/ready channel interfaces for command items and variance result items.
interface rsv_in_if #(
  parameter int SAMPLE_BITS = 16
);
  import rsv_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SUM_W-1:0]       part_sum;
  logic [PSQ_W-1:0]              part_sum_sq;
  logic [PCNT_W-1:0]             part_count;

  modport source (
    output valid, cmd, sample, part_sum, part_sum_sq, part_count,
    input  ready
  );
  modport sink (
    input  valid, cmd, sample, part_sum, part_sum_sq, part_count,
    output ready
  );
endinterface

interface rsv_out_if;
  import rsv_pkg::*;

  logic              valid;
  logic              ready;
  logic [VAR_W-1:0]  variance;
  logic              valid_res;
  logic [OCNT_W-1:0] sample_count;
  logic              overflowed;

  modport source (
    output valid, variance, valid_res, sample_count, overflowed,
    input  ready
  );
  modport sink (
    input  valid, variance, valid_res, sample_count, overflowed,
    output ready
  );
endinterface

// ===== rtl/core/rsv_mac.sv =====
// Shared 32x32 multiply-accumulate unit with a signed wide accumulator.
module rsv_mac (
  input  logic                    clk,
  input  rsv_pkg::mac_ctl_t       ctl,
  output logic [rsv_pkg::MAC_W-1:0] acc
);
  import rsv_pkg::*;

  logic [2*OPND_W-1:0] prod;
  logic [MAC_W-1:0]    term;
  logic [MAC_W-1:0]    acc_r;
  logic [MAC_W-1:0]    acc_nxt;

  assign prod = ctl.a * ctl.b;

  always_comb begin
    case (ctl.sh)
      SH_0:    term = MAC_W'(prod);
      SH_32:   term = MAC_W'({prod, 32'd0});
      SH_64:   term = MAC_W'({prod, 64'd0});
      default: term = '0;
    endcase
  end

  always_comb begin
    case (ctl.op)
      MAC_LOAD: acc_nxt = term;
      MAC_ADD:  acc_nxt = acc_r + term;
      MAC_SUB:  acc_nxt = acc_r - term;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== rtl/core/rsv_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient saturated to 48 bits.
module rsv_div #(
  parameter int NUM_W = 112
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [rsv_pkg::DEN_W-1:0] den,
  output rsv_pkg::div_stat_t        stat,
  output logic [rsv_pkg::VAR_W-1:0] q
);
  import rsv_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [VAR_W-1:0] q_r;
  logic             sat_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_sub;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      q_r   <= {q_r[VAR_W-2:0], ge};
      sat_r <= sat_r | q_r[VAR_W-1];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign q         = sat_r ? '1 : q_r;

endmodule

// ===== rtl/core/running_sample_variance.sv =====
// Running sample variance: accumulators, command sequencer and result register.
//
//  channel | direction | handshake          | payload
//  in_ch   | sink      | valid, ready       | cmd, sample, part_sum, part_sum_sq, part_count
//  out_ch  | source    | valid, ready       | variance, valid_res, sample_count, overflowed
//
// Merge and clear complete in the idle state; add passes through S_SQR, where the shared MAC
// squares the sample, and S_UPD. Emit with fewer than two samples goes straight to S_OUT;
// otherwise the MAC forms the denominator and the numerator; a negative numerator gives zero,
// and any other goes to the one-bit-per-cycle divider over 96 + FRAC_BITS numerator bits.
// Reset is synchronous, active low, and zeroes the accumulators and overflow flag.
// A result held on a stalled out_ch holds the next emit in S_OUT, which then blocks in_ch; earlier items still enter.
module running_sample_variance #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 32,
  parameter int FRAC_BITS   = 16
) (
  input logic        clk,
  input logic        rst_n,
  rsv_in_if.sink     in_ch,
  rsv_out_if.source  out_ch
);
  import rsv_pkg::*;

  localparam int NUM_W = PROD_W + FRAC_BITS;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SQR  = 8'b0000_0010,
    S_UPD  = 8'b0000_0100,
    S_DEN  = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_CHK  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  mul_step_t               step_r, step_nxt;
  logic [SAMPLE_BITS-1:0]  smp_r, smp_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic [COUNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt;
  logic [VAR_W-1:0]        res_var_r, res_var_nxt;
  logic                    res_ok_r, res_ok_nxt;
  logic                    out_vld_r, out_vld_nxt;
  logic [VAR_W-1:0]        out_var_r, out_var_nxt;
  logic                    out_ok_r, out_ok_nxt;
  logic [OCNT_W-1:0]       out_cnt_r, out_cnt_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  logic                    in_acc;
  logic                    upd_sel;
  logic [SUM_W-1:0]        sum_opnd;
  logic [SQ_W-1:0]         sq_opnd;
  logic [PCNT_W-1:0]       cnt_opnd;
  logic [SUM_W:0]          sum_ext;
  logic [SQ_W:0]           sq_ext;
  logic [PCNT_W:0]         cnt_ext;
  logic                    upd_ovf;
  logic [SAMPLE_BITS-1:0]  smp_abs;
  logic [SUM_W-1:0]        sum_abs;
  logic [OPND_W-1:0]       n_op;
  logic [OPND_W-1:0]       nm1_op;
  logic [OPND_W-1:0]       a_lo;
  logic [OPND_W-1:0]       a_hi;
  logic [MAC_W-1:0]        mac_acc;
  mac_ctl_t                mac_ctl;
  logic                    div_start;
  div_stat_t               div_stat;
  logic [VAR_W-1:0]        div_q;
  logic [NUM_W-1:0]        div_num;

  rsv_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .acc (mac_acc)
  );

  rsv_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .stat  (div_stat),
    .q     (div_q)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign upd_sel  = (state_r == S_UPD);
  assign sum_opnd = upd_sel ? SUM_W'(signed'(smp_r)) : SUM_W'(in_ch.part_sum);
  assign sq_opnd  = upd_sel ? mac_acc[SQ_W-1:0] : SQ_W'(in_ch.part_sum_sq);
  assign cnt_opnd = upd_sel ? PCNT_W'(1) : in_ch.part_count;
  assign sum_ext  = {sum_r[SUM_W-1], sum_r} + {sum_opnd[SUM_W-1], sum_opnd};
  assign sq_ext   = {1'b0, sq_r} + {1'b0, sq_opnd};
  assign cnt_ext  = (PCNT_W + 1)'(cnt_r) + {1'b0, cnt_opnd};
  assign upd_ovf  = (sum_ext[SUM_W] != sum_ext[SUM_W-1]) || sq_ext[SQ_W]
                    || ((cnt_ext >> COUNT_BITS) != '0);

  assign smp_abs = smp_r[SAMPLE_BITS-1] ? (~smp_r + 1'b1) : smp_r;
  assign sum_abs = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign n_op    = OPND_W'(cnt_r);
  assign nm1_op  = OPND_W'(cnt_r - COUNT_BITS'(1));
  assign a_lo    = sum_abs[OPND_W-1:0];
  assign a_hi    = OPND_W'(sum_abs[SUM_W-1:OPND_W]);
  assign div_num = NUM_W'(mac_acc[PROD_W-1:0]) << FRAC_BITS;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    smp_nxt     = smp_r;
    sum_nxt     = sum_r;
    sq_nxt      = sq_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    den_nxt     = den_r;
    res_var_nxt = res_var_r;
    res_ok_nxt  = res_ok_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    out_var_nxt = out_var_r;
    out_ok_nxt  = out_ok_r;
    out_cnt_nxt = out_cnt_r;
    out_ovf_nxt = out_ovf_r;
    div_start   = 1'b0;
    mac_ctl     = '{en: 1'b0, op: MAC_LOAD, sh: SH_0, a: '0, b: '0};

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd_t'(in_ch.cmd))
            CMD_ADD: begin
              smp_nxt   = in_ch.sample[SAMPLE_BITS-1:0];
              state_nxt = S_SQR;
            end
            CMD_MERGE: begin
              sum_nxt = sum_ext[SUM_W-1:0];
              sq_nxt  = sq_ext[SQ_W-1:0];
              cnt_nxt = cnt_ext[COUNT_BITS-1:0];
              ovf_nxt = ovf_r | upd_ovf;
            end
            CMD_EMIT: begin
              if (cnt_r > COUNT_BITS'(1)) begin
                state_nxt = S_DEN;
              end else begin
                res_var_nxt = '0;
                res_ok_nxt  = 1'b0;
                state_nxt   = S_OUT;
              end
            end
            CMD_CLEAR: begin
              sum_nxt = '0;
              sq_nxt  = '0;
              cnt_nxt = '0;
              ovf_nxt = 1'b0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SQR: begin
        mac_ctl   = '{en: 1'b1, op: MAC_LOAD, sh: SH_0, a: OPND_W'(smp_abs),
                      b: OPND_W'(smp_abs)};
        state_nxt = S_UPD;
      end
      S_UPD: begin
        sum_nxt   = sum_ext[SUM_W-1:0];
        sq_nxt    = sq_ext[SQ_W-1:0];
        cnt_nxt   = cnt_ext[COUNT_BITS-1:0];
        ovf_nxt   = ovf_r | upd_ovf;
        state_nxt = S_IDLE;
      end
      S_DEN: begin
        mac_ctl   = '{en: 1'b1, op: MAC_LOAD, sh: SH_0, a: n_op, b: nm1_op};
        step_nxt  = MS_N_LO;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        case (step_r)
          MS_N_LO: begin
            den_nxt  = mac_acc[DEN_W-1:0];
            mac_ctl  = '{en: 1'b1, op: MAC_LOAD, sh: SH_0, a: n_op, b: sq_r[31:0]};
            step_nxt = MS_N_HI;
          end
          MS_N_HI: begin
            mac_ctl  = '{en: 1'b1, op: MAC_ADD, sh: SH_32, a: n_op, b: sq_r[63:32]};
            step_nxt = MS_A00;
          end
          MS_A00: begin
            mac_ctl  = '{en: 1'b1, op: MAC_SUB, sh: SH_0, a: a_lo, b: a_lo};
            step_nxt = MS_A01;
          end
          MS_A01: begin
            mac_ctl  = '{en: 1'b1, op: MAC_SUB, sh: SH_32, a: a_lo, b: a_hi};
            step_nxt = MS_A10;
          end
          MS_A10: begin
            mac_ctl  = '{en: 1'b1, op: MAC_SUB, sh: SH_32, a: a_hi, b: a_lo};
            step_nxt = MS_A11;
          end
          MS_A11: begin
            mac_ctl   = '{en: 1'b1, op: MAC_SUB, sh: SH_64, a: a_hi, b: a_hi};
            state_nxt = S_CHK;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CHK: begin
        if (mac_acc[MAC_W-1]) begin
          res_var_nxt = '0;
          res_ok_nxt  = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_var_nxt = div_q;
          res_ok_nxt  = 1'b1;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          out_var_nxt = res_var_r;
          out_ok_nxt  = res_ok_r;
          out_cnt_nxt = OCNT_W'(cnt_r);
          out_ovf_nxt = ovf_r;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= MS_N_LO;
      sum_r     <= '0;
      sq_r      <= '0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      sum_r     <= sum_nxt;
      sq_r      <= sq_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r     <= smp_nxt;
    den_r     <= den_nxt;
    res_var_r <= res_var_nxt;
    res_ok_r  <= res_ok_nxt;
    out_var_r <= out_var_nxt;
    out_ok_r  <= out_ok_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.variance     = out_var_r;
  assign out_ch.valid_res    = out_ok_r;
  assign out_ch.sample_count = out_cnt_r;
  assign out_ch.overflowed   = out_ovf_r;

endmodule

// ===== rtl/core/rsv_chk.sv =====
// Port-level checks for the running sample variance block, bound to the top level.
module rsv_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  in_cmd,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rsv_pkg::VAR_W-1:0]   out_variance,
  input logic                        out_valid_res,
  input logic [rsv_pkg::OCNT_W-1:0]  out_sample_count,
  input logic                        out_overflowed
);
  import rsv_pkg::*;

  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_ADD || in_cmd == CMD_EMIT) |=> !in_ready)
    else $error("block took a new item right after an add or emit");

  a_zero_when_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_variance == '0)
    else $error("variance not zero with too few samples");

  a_count_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_sample_count > OCNT_W'(1))
    else $error("valid result with fewer than two samples");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_variance)
      && $stable(out_valid_res) && $stable(out_sample_count) && $stable(out_overflowed))
    else $error("stalled result item changed");

endmodule

bind running_sample_variance rsv_chk u_rsv_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_cmd           (in_ch.cmd),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_variance     (out_ch.variance),
  .out_valid_res    (out_ch.valid_res),
  .out_sample_count (out_ch.sample_count),
  .out_overflowed   (out_ch.overflowed)
);
